FILE: hw/rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache tag store: field
// widths, configuration register indexes, transfer payloads and the layout
// of one set row in the tag memory.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int MAX_SETS   = 64;
   localparam int MAX_WAYS   = 8;
   localparam int ADDR_BITS  = 48;

   localparam int SET_W      = $clog2(MAX_SETS);
   localparam int WAY_W      = $clog2(MAX_WAYS);
   localparam int TAG_W      = ADDR_BITS;
   localparam int STAMP_W    = 32;
   localparam int CNT_W      = 32;

   localparam int OFFSET_W   = 4;
   localparam int INDEX_W    = 3;
   localparam int WAYS_W     = 4;
   localparam int CSR_DATA_W = 4;
   localparam int CSR_ADDR_W = 2;

   localparam logic ACTION_WRITE = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2,
      CSR_USE_LRU     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 action;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic             mem_read;
      logic             mem_write;
      logic [CNT_W-1:0] total_reads;
      logic [CNT_W-1:0] total_writes;
      logic [CNT_W-1:0] total_hits;
      logic [CNT_W-1:0] total_misses;
   } rsp_type;

   // One set: valid bit, tag and age stamp of every way.
   typedef struct packed {
      logic [MAX_WAYS-1:0]              way_valid;
      logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
      logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
   } row_type;

endpackage

FILE: hw/rtl/set_assoc_cache_lru_fifo_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_unit
// Tag store of a set-associative, write-through, write-allocate cache with
// LRU or FIFO replacement and running memory, hit and miss totals.
// ----------------------------------------------------------------------------
// Each access runs through set row read, tag compare with the first level of
// the oldest-stamp search, then victim choice and row write back. One access
// is in flight at a time, and the next is taken once its row is written back;
// the result register lets the next access start while a result waits.
// Reset clears the row flags of the tag memory and all counters at once and
// restores the configuration defaults; the block is ready the next cycle.
module set_assoc_cache_lru_fifo_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sacl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sacl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_en,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic                          cand;
      logic [sacl_pkg::WAY_W-1:0]    way;
      logic [sacl_pkg::STAMP_W-1:0]  stamp;
   } cand_type;

   localparam int PAIRS = sacl_pkg::MAX_WAYS / 2;

   // Configuration
   logic [sacl_pkg::OFFSET_W-1:0] offset_bits_ff, offset_bits_in;
   logic [sacl_pkg::INDEX_W-1:0]  index_bits_ff, index_bits_in;
   logic [sacl_pkg::WAYS_W-1:0]   ways_in_use_ff, ways_in_use_in;
   logic                          use_lru_ff, use_lru_in;

   // Control and access context
   state_type                     state_ff, state_in;
   logic [sacl_pkg::SET_W-1:0]    set_ff, set_in;
   logic [sacl_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic                          is_write_ff, is_write_in;

   // Compare stage results
   logic                          hit_ff, hit_in;
   logic [sacl_pkg::WAY_W-1:0]    hit_way_ff, hit_way_in;
   logic                          has_inv_ff, has_inv_in;
   logic [sacl_pkg::WAY_W-1:0]    inv_way_ff, inv_way_in;
   cand_type [PAIRS-1:0]          pair_ff, pair_in;

   // Counters and result register
   logic [sacl_pkg::CNT_W-1:0]    access_count_ff, access_count_in;
   logic [sacl_pkg::CNT_W-1:0]    read_count_ff, read_count_in;
   logic [sacl_pkg::CNT_W-1:0]    write_count_ff, write_count_in;
   logic [sacl_pkg::CNT_W-1:0]    hit_count_ff, hit_count_in;
   logic [sacl_pkg::CNT_W-1:0]    miss_count_ff, miss_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sacl_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // Datapath
   logic                          req_take;
   logic [sacl_pkg::ADDR_BITS-1:0] blk;
   logic [sacl_pkg::SET_W-1:0]    idx_mask;
   logic [sacl_pkg::WAYS_W-1:0]   ways_eff;
   logic [sacl_pkg::MAX_WAYS-1:0] way_on;
   sacl_pkg::row_type             rd_row;
   sacl_pkg::row_type             wr_row;
   logic                          wr_en;
   logic                          upd_go;
   cand_type                      oldest;
   logic [sacl_pkg::WAY_W-1:0]    victim;
   logic [sacl_pkg::STAMP_W-1:0]  stamp_new;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Address split into block number, set index and tag.
   assign blk      = req_data.address >> offset_bits_ff;
   assign idx_mask = ~({sacl_pkg::SET_W{1'b1}} << index_bits_ff);
   assign set_in   = req_take ? (blk[sacl_pkg::SET_W-1:0] & idx_mask) : set_ff;
   assign tag_in   = req_take ? (blk >> index_bits_ff) : tag_ff;
   assign is_write_in = req_take ? (req_data.action == sacl_pkg::ACTION_WRITE) : is_write_ff;

   always_comb begin
      if (ways_in_use_ff == '0) begin
         ways_eff = sacl_pkg::WAYS_W'(1);
      end else if (ways_in_use_ff > sacl_pkg::WAYS_W'(sacl_pkg::MAX_WAYS)) begin
         ways_eff = sacl_pkg::WAYS_W'(sacl_pkg::MAX_WAYS);
      end else begin
         ways_eff = ways_in_use_ff;
      end
      for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
         way_on[w] = (sacl_pkg::WAYS_W'(w) < ways_eff);
      end
   end

   sacl_row_ram u_row_ram (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_take),
      .rd_set (set_in),
      .rd_row (rd_row),
      .wr_en  (wr_en),
      .wr_set (set_ff),
      .wr_row (wr_row)
   );

   // Compare stage: tag match, first free way, first level of the age search.
   always_comb begin
      logic                 found;
      logic                 free;
      logic                 take_right;
      cand_type             lc;
      cand_type             rc;
      found      = 1'b0;
      free       = 1'b0;
      hit_way_in = '0;
      inv_way_in = '0;
      for (int w = sacl_pkg::MAX_WAYS - 1; w >= 0; w--) begin
         if (way_on[w] && rd_row.way_valid[w] && (rd_row.tag[w] == tag_ff)) begin
            found      = 1'b1;
            hit_way_in = sacl_pkg::WAY_W'(w);
         end
         if (way_on[w] && !rd_row.way_valid[w]) begin
            free       = 1'b1;
            inv_way_in = sacl_pkg::WAY_W'(w);
         end
      end
      hit_in     = found;
      has_inv_in = free;
      for (int p = 0; p < PAIRS; p++) begin
         lc.cand  = way_on[2*p];
         lc.way   = sacl_pkg::WAY_W'(2*p);
         lc.stamp = rd_row.stamp[2*p];
         rc.cand  = way_on[2*p+1];
         rc.way   = sacl_pkg::WAY_W'(2*p+1);
         rc.stamp = rd_row.stamp[2*p+1];
         // The lower way wins ties, so the right one needs a strictly older stamp.
         take_right = rc.cand && (!lc.cand || (rc.stamp < lc.stamp));
         pair_in[p] = take_right ? rc : lc;
      end
   end

   // Update stage: finish the age search, pick the way and build the new row.
   always_comb begin
      oldest = pair_ff[0];
      for (int p = 1; p < PAIRS; p++) begin
         if (pair_ff[p].cand && (!oldest.cand || (pair_ff[p].stamp < oldest.stamp))) begin
            oldest = pair_ff[p];
         end
      end
      if (hit_ff) begin
         victim = hit_way_ff;
      end else if (has_inv_ff) begin
         victim = inv_way_ff;
      end else begin
         victim = oldest.way;
      end
      stamp_new = access_count_ff + sacl_pkg::STAMP_W'(1);
      wr_row    = rd_row;
      if (hit_ff) begin
         if (use_lru_ff) begin
            wr_row.stamp[victim] = stamp_new;
         end
      end else begin
         wr_row.way_valid[victim] = 1'b1;
         wr_row.tag[victim]       = tag_ff;
         wr_row.stamp[victim]     = stamp_new;
      end
   end

   assign upd_go = (state_ff == ST_UPD) && (!rsp_valid_ff || !rsp_stall);
   assign wr_en  = upd_go;

   always_comb begin
      state_in        = state_ff;
      access_count_in = access_count_ff;
      read_count_in   = read_count_ff;
      write_count_in  = write_count_ff;
      hit_count_in    = hit_count_ff;
      miss_count_in   = miss_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) begin
               state_in        = ST_IDLE;
               access_count_in = stamp_new;
               if (hit_ff) begin
                  hit_count_in = hit_count_ff + sacl_pkg::CNT_W'(1);
               end else begin
                  miss_count_in = miss_count_ff + sacl_pkg::CNT_W'(1);
                  read_count_in = read_count_ff + sacl_pkg::CNT_W'(1);
               end
               if (is_write_ff) begin
                  write_count_in = write_count_ff + sacl_pkg::CNT_W'(1);
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.hit          = hit_ff;
               rsp_data_in.mem_read     = !hit_ff;
               rsp_data_in.mem_write    = is_write_ff;
               rsp_data_in.total_reads  = read_count_in;
               rsp_data_in.total_writes = write_count_in;
               rsp_data_in.total_hits   = hit_count_in;
               rsp_data_in.total_misses = miss_count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_in_use_in = ways_in_use_ff;
      use_lru_in     = use_lru_ff;
      if (csr_write_en) begin
         case (sacl_pkg::csr_index_type'(csr_index))
            sacl_pkg::CSR_OFFSET_BITS: offset_bits_in = csr_wdata[sacl_pkg::OFFSET_W-1:0];
            sacl_pkg::CSR_INDEX_BITS:  index_bits_in  = csr_wdata[sacl_pkg::INDEX_W-1:0];
            sacl_pkg::CSR_WAYS_IN_USE: ways_in_use_in = csr_wdata[sacl_pkg::WAYS_W-1:0];
            sacl_pkg::CSR_USE_LRU:     use_lru_in     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Access context and compare results are payload and need no reset.
   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      is_write_ff <= is_write_in;
      if (state_ff == ST_CMP) begin
         hit_ff     <= hit_in;
         hit_way_ff <= hit_way_in;
         has_inv_ff <= has_inv_in;
         inv_way_ff <= inv_way_in;
         pair_ff    <= pair_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         offset_bits_ff  <= sacl_pkg::OFFSET_W'(6);
         index_bits_ff   <= sacl_pkg::INDEX_W'(6);
         ways_in_use_ff  <= sacl_pkg::WAYS_W'(1);
         use_lru_ff      <= 1'b1;
         access_count_ff <= '0;
         read_count_ff   <= '0;
         write_count_ff  <= '0;
         hit_count_ff    <= '0;
         miss_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         offset_bits_ff  <= offset_bits_in;
         index_bits_ff   <= index_bits_in;
         ways_in_use_ff  <= ways_in_use_in;
         use_lru_ff      <= use_lru_in;
         access_count_ff <= access_count_in;
         read_count_ff   <= read_count_in;
         write_count_ff  <= write_count_in;
         hit_count_ff    <= hit_count_in;
         miss_count_ff   <= miss_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/sacl_row_ram.sv
// ----------------------------------------------------------------------------
// sacl_row_ram
// Tag memory with one row per set and a registered read. A flag per row marks
// rows written since reset; a row never written reads as all ways invalid.
// ----------------------------------------------------------------------------
module sacl_row_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [sacl_pkg::SET_W-1:0]  rd_set,
   output sacl_pkg::row_type           rd_row,
   input  logic                        wr_en,
   input  logic [sacl_pkg::SET_W-1:0]  wr_set,
   input  sacl_pkg::row_type           wr_row
);

   sacl_pkg::row_type               mem [sacl_pkg::MAX_SETS];
   logic [sacl_pkg::MAX_SETS-1:0]   row_seen_ff;
   logic [sacl_pkg::MAX_SETS-1:0]   row_seen_in;
   sacl_pkg::row_type               rd_data_ff;
   logic                            rd_seen_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_set] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_set];
      end
   end

   always_comb begin
      row_seen_in = row_seen_ff;
      if (wr_en) begin
         row_seen_in[wr_set] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_seen_ff <= '0;
         rd_seen_ff  <= 1'b0;
      end else begin
         row_seen_ff <= row_seen_in;
         if (rd_en) begin
            rd_seen_ff <= row_seen_ff[rd_set];
         end
      end
   end

   always_comb begin
      rd_row = rd_data_ff;
      if (!rd_seen_ff) begin
         rd_row.way_valid = '0;
      end
   end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the set-associative cache tag store. A short
// table of directed accesses and register writes runs first, then random
// accesses in phases with different cache geometries and replacement modes.
// Each accepted access is run through a behavioral copy of the tag store,
// and every result transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   LINES       = sacl_pkg::MAX_SETS * sacl_pkg::MAX_WAYS;
   localparam int   PHASES      = 12;
   localparam int   PHASE_ITEMS = 160;
   localparam logic ACTION_READ = ~sacl_pkg::ACTION_WRITE;

   // Expected {hit, mem_read, mem_write} for directed rows.
   localparam logic [2:0] MISS_RD = 3'b010;
   localparam logic [2:0] MISS_WR = 3'b011;
   localparam logic [2:0] HIT_RD  = 3'b100;
   localparam logic [2:0] HIT_WR  = 3'b101;

   typedef struct packed {
      logic                    is_csr;
      sacl_pkg::csr_index_type csr_idx;
      logic [3:0]              csr_val;
      sacl_pkg::req_type       acc;
      logic                    typed;
      logic [2:0]              flags;
   } plan_row_type;

   logic                    clock;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_stall;
   sacl_pkg::req_type       req_data     = '0;
   logic                    rsp_valid;
   logic                    rsp_stall    = 1'b0;
   sacl_pkg::rsp_type       rsp_data;
   logic                    csr_write_en = 1'b0;
   sacl_pkg::csr_index_type csr_index    = sacl_pkg::CSR_OFFSET_BITS;
   logic [3:0]              csr_wdata    = '0;

   // Behavioral copy of the tag store and its configuration.
   bit          line_ok   [LINES];
   logic [47:0] line_tagv [LINES];
   logic [31:0] line_age  [LINES];
   logic [31:0] n_access, n_rd, n_wr, n_hit, n_miss;
   logic [3:0]  m_offset;
   logic [2:0]  m_index;
   logic [3:0]  m_ways;
   logic        m_lru;

   sacl_pkg::rsp_type outcome_q [$];
   plan_row_type      directed_plan [$];
   int                bad_count     = 0;
   int                send_idle_pct = 12;
   int                rsp_idle_pct  = 47;

   set_assoc_cache_lru_fifo_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // Looks the access up in the set, updates lines and totals, and returns
   // the result the block should produce.
   function automatic sacl_pkg::rsp_type lookup_outcome(sacl_pkg::req_type r);
      sacl_pkg::rsp_type o;
      int unsigned       ways, base, victim, w, set_no;
      logic [47:0]       blk, tagv;
      bit                found;
      ways = (m_ways == 0) ? 1 : ((int'(m_ways) > sacl_pkg::MAX_WAYS) ?
             sacl_pkg::MAX_WAYS : int'(m_ways));
      n_access = n_access + 1;
      blk    = r.address >> m_offset;
      set_no = int'(blk & ((48'd1 << m_index) - 48'd1)) % sacl_pkg::MAX_SETS;
      tagv   = blk >> m_index;
      base   = set_no * sacl_pkg::MAX_WAYS;
      found  = 1'b0;
      for (w = 0; w < ways && !found; w++) begin
         if (line_ok[base + w] && line_tagv[base + w] == tagv) begin
            found = 1'b1;
            if (m_lru) line_age[base + w] = n_access;
         end
      end
      if (!found) begin
         victim = ways;
         for (w = 0; w < ways; w++) begin
            if (!line_ok[base + w] && victim == ways) victim = w;
         end
         // All ways full: the lowest way with the oldest stamp goes.
         if (victim == ways) begin
            victim = 0;
            for (w = 1; w < ways; w++) begin
               if (line_age[base + w] < line_age[base + victim]) victim = w;
            end
         end
         line_ok[base + victim]   = 1'b1;
         line_tagv[base + victim] = tagv;
         line_age[base + victim]  = n_access;
         n_miss = n_miss + 1;
         n_rd   = n_rd + 1;
      end else begin
         n_hit = n_hit + 1;
      end
      if (r.action == sacl_pkg::ACTION_WRITE) n_wr = n_wr + 1;
      o.hit          = found;
      o.mem_read     = !found;
      o.mem_write    = (r.action == sacl_pkg::ACTION_WRITE);
      o.total_reads  = n_rd;
      o.total_writes = n_wr;
      o.total_hits   = n_hit;
      o.total_misses = n_miss;
      return o;
   endfunction

   function automatic plan_row_type acc_row(logic action, logic [47:0] addr, logic typed,
                                            logic [2:0] flags);
      plan_row_type p;
      p             = '0;
      p.acc.action  = action;
      p.acc.address = addr;
      p.typed       = typed;
      p.flags       = flags;
      return p;
   endfunction

   function automatic plan_row_type csr_row(sacl_pkg::csr_index_type idx, logic [3:0] val);
      plan_row_type p;
      p         = '0;
      p.is_csr  = 1'b1;
      p.csr_idx = idx;
      p.csr_val = val;
      return p;
   endfunction

   // Registers change only with nothing in flight.
   task automatic write_csr(sacl_pkg::csr_index_type idx, logic [3:0] val);
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         sacl_pkg::CSR_OFFSET_BITS: m_offset = val;
         sacl_pkg::CSR_INDEX_BITS:  m_index  = val[2:0];
         sacl_pkg::CSR_WAYS_IN_USE: m_ways   = val;
         sacl_pkg::CSR_USE_LRU:     m_lru    = val[0];
         default: ;
      endcase
   endtask

   task automatic issue_access(sacl_pkg::req_type r, logic typed, logic [2:0] flags);
      sacl_pkg::rsp_type o;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      o = lookup_outcome(r);
      if (typed) {o.hit, o.mem_read, o.mem_write} = flags;
      outcome_q.push_back(o);
   endtask

   task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         bad_count++;
         if (bad_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // Result side: checks each transfer and drives the stall, with two long
   // hold-offs so that the block backs up into its input.
   initial begin : rsp_side
      sacl_pkg::rsp_type want;
      int                hold_left;
      int                seen;
      hold_left = 0;
      seen      = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen++;
            if (outcome_q.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("result transfer with nothing outstanding: %h", rsp_data);
            end else begin
               want = outcome_q.pop_front();
               flag_field("hit", want.hit, rsp_data.hit);
               flag_field("mem_read", want.mem_read, rsp_data.mem_read);
               flag_field("mem_write", want.mem_write, rsp_data.mem_write);
               flag_field("total_reads", want.total_reads, rsp_data.total_reads);
               flag_field("total_writes", want.total_writes, rsp_data.total_writes);
               flag_field("total_hits", want.total_hits, rsp_data.total_hits);
               flag_field("total_misses", want.total_misses, rsp_data.total_misses);
            end
            if (seen == 400 || seen == 1300) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   initial begin : req_side
      int                k, ph, i, t, s, n_tags, n_sets, pick;
      logic [15:0]       cfg;
      logic [47:0]       hot_tag [12];
      logic [6:0]        hot_set [3];
      logic [47:0]       rnd, addr;
      sacl_pkg::req_type r;

      m_offset = 4'd6;
      m_index  = 3'd6;
      m_ways   = 4'd1;
      m_lru    = 1'b1;
      n_access = '0;
      n_rd     = '0;
      n_wr     = '0;
      n_hit    = '0;
      n_miss   = '0;
      foreach (line_ok[k]) line_ok[k] = 1'b0;

      // Defaults after reset: 64-byte blocks, 64 sets, direct mapped, LRU.
      directed_plan.push_back(acc_row(ACTION_READ,  48'h0, 1'b1, MISS_RD));
      directed_plan.push_back(acc_row(sacl_pkg::ACTION_WRITE, 48'h0, 1'b1, HIT_WR));
      directed_plan.push_back(acc_row(ACTION_READ,  48'hFFFF_FFFF_FFFF, 1'b1, MISS_RD));
      directed_plan.push_back(acc_row(sacl_pkg::ACTION_WRITE, 48'hFFFF_FFFF_FFFF, 1'b1,
                                      HIT_WR));
      directed_plan.push_back(acc_row(sacl_pkg::ACTION_WRITE, 48'h1000, 1'b1, MISS_WR));
      directed_plan.push_back(acc_row(ACTION_READ,  48'h0, 1'b1, MISS_RD));
      // Zero ways behaves as one way.
      directed_plan.push_back(csr_row(sacl_pkg::CSR_WAYS_IN_USE, 4'd0));
      directed_plan.push_back(acc_row(ACTION_READ,  48'h1000, 1'b1, MISS_RD));
      // Index field wider than the store, largest block size.
      directed_plan.push_back(csr_row(sacl_pkg::CSR_INDEX_BITS, 4'd7));
      directed_plan.push_back(csr_row(sacl_pkg::CSR_OFFSET_BITS, 4'd15));
      directed_plan.push_back(acc_row(sacl_pkg::ACTION_WRITE, 48'hABCD_EF01_2345, 1'b0,
                                      3'b000));
      directed_plan.push_back(acc_row(ACTION_READ,  48'hABCD_EF01_2345, 1'b1, HIT_RD));
      // One set, byte blocks, ways saturated to the maximum, FIFO order;
      // stale lines from earlier settings stay in place.
      directed_plan.push_back(csr_row(sacl_pkg::CSR_OFFSET_BITS, 4'd0));
      directed_plan.push_back(csr_row(sacl_pkg::CSR_INDEX_BITS, 4'd0));
      directed_plan.push_back(csr_row(sacl_pkg::CSR_WAYS_IN_USE, 4'd15));
      directed_plan.push_back(csr_row(sacl_pkg::CSR_USE_LRU, 4'd0));
      for (k = 0; k < 9; k++)
         directed_plan.push_back(acc_row(ACTION_READ, 48'h10 + k, 1'b0, 3'b000));
      directed_plan.push_back(acc_row(ACTION_READ, 48'h10, 1'b0, 3'b000));
      // Two ways under LRU: the refreshed line survives the next miss.
      directed_plan.push_back(csr_row(sacl_pkg::CSR_USE_LRU, 4'd1));
      directed_plan.push_back(csr_row(sacl_pkg::CSR_WAYS_IN_USE, 4'd2));
      directed_plan.push_back(acc_row(ACTION_READ, 48'h20, 1'b1, MISS_RD));
      directed_plan.push_back(acc_row(ACTION_READ, 48'h21, 1'b1, MISS_RD));
      directed_plan.push_back(acc_row(ACTION_READ, 48'h20, 1'b1, HIT_RD));
      directed_plan.push_back(acc_row(ACTION_READ, 48'h22, 1'b1, MISS_RD));
      directed_plan.push_back(acc_row(ACTION_READ, 48'h21, 1'b1, MISS_RD));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) begin
         if (directed_plan[k].is_csr)
            write_csr(directed_plan[k].csr_idx, directed_plan[k].csr_val);
         else
            issue_access(directed_plan[k].acc, directed_plan[k].typed,
                         directed_plan[k].flags);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = (ph < 4) ? 12 : ((ph < 8) ? 47 : 0);
         rsp_idle_pct  = (ph < 4) ? 47 : ((ph < 8) ? 12 : 0);
         // Nibbles: offset bits, index bits, ways, replacement mode.
         case (ph)
            0:       cfg = {4'd6,  4'd6, 4'd1,  4'd1};
            1:       cfg = {4'd0,  4'd0, 4'd8,  4'd1};
            2:       cfg = {4'd15, 4'd7, 4'd4,  4'd0};
            3:       cfg = {4'd12, 4'd6, 4'd8,  4'd0};
            4:       cfg = {4'd3,  4'd2, 4'd2,  4'd1};
            5:       cfg = {4'd0,  4'd7, 4'd0,  4'd1};
            default: cfg = 16'($urandom);
         endcase
         write_csr(sacl_pkg::CSR_OFFSET_BITS, cfg[15:12]);
         write_csr(sacl_pkg::CSR_INDEX_BITS,  cfg[11:8]);
         write_csr(sacl_pkg::CSR_WAYS_IN_USE, cfg[7:4]);
         write_csr(sacl_pkg::CSR_USE_LRU,     cfg[3:0]);

         // A few tags over a few sets, so that lines get reused and evicted.
         n_tags = $urandom_range(2, 12);
         n_sets = $urandom_range(1, 3);
         foreach (hot_tag[k]) hot_tag[k] = 48'({$urandom, $urandom});
         foreach (hot_set[k]) hot_set[k] = 7'($urandom);

         for (i = 0; i < PHASE_ITEMS; i++) begin
            rnd  = 48'({$urandom, $urandom});
            pick = $urandom_range(99);
            if (pick < 78) begin
               t    = $urandom_range(n_tags - 1);
               s    = $urandom_range(n_sets - 1);
               addr = (hot_tag[t] << (int'(m_offset) + int'(m_index)))
                    | (48'(hot_set[s] & ((7'd1 << m_index) - 7'd1)) << m_offset)
                    | (rnd & ((48'd1 << m_offset) - 48'd1));
            end else if (pick < 94) begin
               addr = rnd;
            end else if (pick < 97) begin
               addr = 48'h0;
            end else begin
               addr = 48'hFFFF_FFFF_FFFF;
            end
            r.action  = 1'($urandom);
            r.address = addr;
            issue_access(r, 1'b0, 3'b000);
         end
      end

      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (bad_count == 0 && outcome_q.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
